// ===== rtl/status_led_change_sender_defines.svh =====
// Assertion helpers for the status LED sender modules (used by slcs_back).
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef STATUS_LED_CHANGE_SENDER_DEFINES_SVH
`define STATUS_LED_CHANGE_SENDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLCS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slcs_pkg.sv =====
`timescale 1ns / 1ps

package slcs_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_RECONNECT = 2'd1,
        CMD_READY     = 2'd2
    } slcs_cmd_t;

    // Configuration register indexes (word address bits).
    typedef enum logic [2:0] {
        REG_IDLE_RED       = 3'd0,
        REG_IDLE_GREEN     = 3'd1,
        REG_IDLE_BLUE      = 3'd2,
        REG_IDLE_WHITE     = 3'd3,
        REG_EXT_BRIGHTNESS = 3'd4
    } slcs_reg_t;

    // Channel numbers; bit positions of the write mask follow them.
    localparam logic [2:0] CH_RED       = 3'd0;
    localparam logic [2:0] CH_GREEN     = 3'd1;
    localparam logic [2:0] CH_BLUE      = 3'd2;
    localparam logic [2:0] CH_WHITE     = 3'd3;
    localparam logic [2:0] CH_EXT_FIRST = 3'd4;
    localparam int         NUM_CH       = 8;

    localparam logic [7:0] FULL_LEVEL   = 8'd255;
    localparam logic [7:0] STATUS_WHITE = 8'd20;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0] idle_red;
        logic [7:0] idle_green;
        logic [7:0] idle_blue;
        logic [7:0] idle_white;
        logic [7:0] ext_brightness;
    } slcs_cfg_t;

    // One tick's worth of channel writes; lvl_ext is already inverted.
    typedef struct packed {
        logic [NUM_CH-1:0] mask;
        logic [7:0]        lvl_red;
        logic [7:0]        lvl_green;
        logic [7:0]        lvl_blue;
        logic [7:0]        lvl_white;
        logic [7:0]        lvl_ext;
    } slcs_job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } slcs_fifo_status_t;

endpackage

// ===== rtl/slcs_fifo.sv =====
`timescale 1ns / 1ps

module slcs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  slcs_pkg::slcs_job_t         push_data,
    input  logic                        pop,
    output slcs_pkg::slcs_job_t         pop_data,
    output slcs_pkg::slcs_fifo_status_t status
);
    import slcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slcs_job_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/slcs_front.sv =====
`timescale 1ns / 1ps

module slcs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slcs_pkg::slcs_cfg_t         cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic                        standby_mode,
    input  logic                        brew_mode,
    input  logic                        brew_running,
    input  logic                        snap_exists,
    input  logic                        snap_active,
    input  logic                        snap_is_brew,
    input  logic                        water_low,
    input  slcs_pkg::slcs_fifo_status_t fifo_status,
    output logic                        push,
    output slcs_pkg::slcs_job_t         push_data
);
    import slcs_pkg::*;

    logic       ready_flag_reg, ready_flag_next;
    logic       resend_reg, resend_next;
    logic [7:0] sent_red_reg, sent_red_next;
    logic [7:0] sent_green_reg, sent_green_next;
    logic [7:0] sent_blue_reg, sent_blue_next;
    logic [7:0] sent_white_reg, sent_white_next;
    logic [7:0] sent_ext_reg, sent_ext_next;

    logic       accept;
    logic       is_tick;
    logic [7:0] r, g, b, w, e;
    logic       ext_change;
    logic [NUM_CH-1:0] mask;

    assign in_ready = !fifo_status.full;
    assign accept   = in_valid && in_ready;

    // Status colour by priority.
    always_comb
    begin
        e = cfg.ext_brightness;
        w = STATUS_WHITE;
        if (standby_mode)
        begin
            r = '0;
            g = '0;
            b = '0;
            w = '0;
            e = '0;
        end
        else if (brew_running && brew_mode)
        begin
            r = '0;
            g = '0;
            b = FULL_LEVEL;
        end
        else if (snap_exists && !snap_active && snap_is_brew && brew_mode)
        begin
            r = '0;
            g = FULL_LEVEL;
            b = '0;
        end
        else if (water_low)
        begin
            r = FULL_LEVEL;
            g = '0;
            b = '0;
        end
        else
        begin
            r = cfg.idle_red;
            g = cfg.idle_green;
            b = cfg.idle_blue;
            w = cfg.idle_white;
        end
    end

    // Channels that must be written: changed ones, or all on a resend.
    assign ext_change = resend_reg || (e != sent_ext_reg);
    always_comb
    begin
        mask               = '0;
        mask[CH_RED]       = resend_reg || (r != sent_red_reg);
        mask[CH_GREEN]     = resend_reg || (g != sent_green_reg);
        mask[CH_BLUE]      = resend_reg || (b != sent_blue_reg);
        mask[CH_WHITE]     = resend_reg || (w != sent_white_reg);
        for (int i = int'(CH_EXT_FIRST); i < NUM_CH; i++)
        begin
            mask[i] = ext_change;
        end
    end

    assign push_data.mask      = mask;
    assign push_data.lvl_red   = r;
    assign push_data.lvl_green = g;
    assign push_data.lvl_blue  = b;
    assign push_data.lvl_white = w;
    assign push_data.lvl_ext   = FULL_LEVEL - e;

    // Command decode.
    always_comb
    begin
        is_tick         = 1'b0;
        ready_flag_next = ready_flag_reg;
        resend_next     = resend_reg;
        if (accept)
        begin
            unique case (cmd)
                CMD_TICK:      is_tick = ready_flag_reg;
                CMD_RECONNECT: resend_next = 1'b1;
                CMD_READY:     ready_flag_next = 1'b1;
                default:       is_tick = 1'b0;
            endcase
        end
        if (is_tick)
        begin
            resend_next = 1'b0;
        end
    end

    assign push = is_tick && (mask != '0);

    // Last sent values follow every tick taken after ready.
    always_comb
    begin
        sent_red_next   = sent_red_reg;
        sent_green_next = sent_green_reg;
        sent_blue_next  = sent_blue_reg;
        sent_white_next = sent_white_reg;
        sent_ext_next   = sent_ext_reg;
        if (is_tick)
        begin
            sent_red_next   = r;
            sent_green_next = g;
            sent_blue_next  = b;
            sent_white_next = w;
            sent_ext_next   = e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_flag_reg <= 1'b0;
            resend_reg     <= 1'b1;
            sent_red_reg   <= '0;
            sent_green_reg <= '0;
            sent_blue_reg  <= '0;
            sent_white_reg <= '0;
            sent_ext_reg   <= '0;
        end
        else
        begin
            ready_flag_reg <= ready_flag_next;
            resend_reg     <= resend_next;
            sent_red_reg   <= sent_red_next;
            sent_green_reg <= sent_green_next;
            sent_blue_reg  <= sent_blue_next;
            sent_white_reg <= sent_white_next;
            sent_ext_reg   <= sent_ext_next;
        end
    end

endmodule

// ===== rtl/slcs_back.sv =====
`timescale 1ns / 1ps

module slcs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slcs_pkg::slcs_fifo_status_t fifo_status,
    input  slcs_pkg::slcs_job_t         pop_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  channel,
    output logic [7:0]                  level,
    output logic                        last_write
);
    import slcs_pkg::*;

    `include "status_led_change_sender_defines.svh"

    slcs_job_t         job_reg, job_next;
    logic [NUM_CH-1:0] mask_reg, mask_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        channel_reg;
    logic [7:0]        level_reg;
    logic              last_reg;

    logic              busy;
    logic              slot_free;
    logic              emit;
    logic [NUM_CH-1:0] sel;
    logic [NUM_CH-1:0] mask_rest;
    logic              last;
    logic [2:0]        sel_ch;
    logic [7:0]        sel_lvl;

    assign busy      = (mask_reg != '0);
    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = busy && slot_free;

    // Lowest pending channel goes out first.
    assign sel       = mask_reg & (~mask_reg + 1'b1);
    assign mask_rest = mask_reg & ~sel;
    assign last      = (mask_rest == '0);

    always_comb
    begin
        sel_ch = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (sel[i])
            begin
                sel_ch = 3'(i);
            end
        end
    end

    always_comb
    begin
        case (sel_ch)
            CH_RED:   sel_lvl = job_reg.lvl_red;
            CH_GREEN: sel_lvl = job_reg.lvl_green;
            CH_BLUE:  sel_lvl = job_reg.lvl_blue;
            CH_WHITE: sel_lvl = job_reg.lvl_white;
            default:  sel_lvl = job_reg.lvl_ext;
        endcase
    end

    // Take the next job when idle or while sending the current job's last beat.
    assign pop = !fifo_status.empty && (!busy || (emit && last));

    always_comb
    begin
        job_next  = job_reg;
        mask_next = mask_reg;
        if (pop)
        begin
            job_next  = pop_data;
            mask_next = pop_data.mask;
        end
        else if (emit)
        begin
            mask_next = mask_rest;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            channel_reg <= sel_ch;
            level_reg   <= sel_lvl;
            last_reg    <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign channel    = channel_reg;
    assign level      = level_reg;
    assign last_write = last_reg;

    // A new job never overwrites one with beats still to send.
    `SLCS_ASSERT_IMPLIES(a_pop_only_when_done, pop, !busy || (emit && last), "pop with beats left")
    // A sent beat always lands in the output register.
    `SLCS_ASSERT_NEXT(a_emit_fills_output, emit, out_valid_reg, "beat sent but output not valid")
    // A beat that is not the last leaves work pending.
    `SLCS_ASSERT_NEXT(a_job_continues, emit && !last, busy, "job ended without a last beat")

endmodule

// ===== rtl/status_led_change_sender.sv =====
// Status LED change sender.
// Input channel (in_valid/in_ready) takes one command beat: an update tick,
// a reconnect, or a controller-ready notice, with the machine status flags.
// Each tick taken after the ready notice yields zero to eight channel-write
// beats on the output channel (out_valid/out_ready), in channel order, with
// last_write set on the final beat of the tick. Only changed channels are
// written, or all of them after reset or a reconnect.
// The first write of a tick passes through the job queue, the job and mask
// registers and the output register. Throughput: one write beat per cycle while
// out_ready is held high; the single output register of the write sequencer
// sets that rate. Commands that cause no writes are taken every cycle while
// the job queue has room.
// The job queue (FIFO_DEPTH entries) lets the front keep taking items while
// the receiver stalls; in_ready drops only when the queue is full.
// Reset clears the queue and output, marks the controller not ready, and arms
// a full resend. Configuration registers are written over the APB port; the user
// writes them only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module status_led_change_sender #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic        standby_mode,
    input  logic        brew_mode,
    input  logic        brew_running,
    input  logic        snap_exists,
    input  logic        snap_active,
    input  logic        snap_is_brew,
    input  logic        water_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  channel,
    output logic [7:0]  level,
    output logic        last_write
);
    import slcs_pkg::*;

    slcs_cfg_t         cfg_reg, cfg_next;
    logic              cfg_write;
    logic [2:0]        reg_idx;
    slcs_fifo_status_t fifo_status;
    logic              push;
    logic              pop;
    slcs_job_t         push_data;
    slcs_job_t         pop_data;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_IDLE_RED:       cfg_next.idle_red       = pwdata[7:0];
                REG_IDLE_GREEN:     cfg_next.idle_green     = pwdata[7:0];
                REG_IDLE_BLUE:      cfg_next.idle_blue      = pwdata[7:0];
                REG_IDLE_WHITE:     cfg_next.idle_white     = pwdata[7:0];
                REG_EXT_BRIGHTNESS: cfg_next.ext_brightness = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read decode.
    always_comb
    begin
        unique case (reg_idx)
            REG_IDLE_RED:       prdata = {24'd0, cfg_reg.idle_red};
            REG_IDLE_GREEN:     prdata = {24'd0, cfg_reg.idle_green};
            REG_IDLE_BLUE:      prdata = {24'd0, cfg_reg.idle_blue};
            REG_IDLE_WHITE:     prdata = {24'd0, cfg_reg.idle_white};
            REG_EXT_BRIGHTNESS: prdata = {24'd0, cfg_reg.ext_brightness};
            default:            prdata = '0;
        endcase
    end

    slcs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .standby_mode (standby_mode),
        .brew_mode    (brew_mode),
        .brew_running (brew_running),
        .snap_exists  (snap_exists),
        .snap_active  (snap_active),
        .snap_is_brew (snap_is_brew),
        .water_low    (water_low),
        .fifo_status  (fifo_status),
        .push         (push),
        .push_data    (push_data)
    );

    slcs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_status)
    );

    slcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_status (fifo_status),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel     (channel),
        .level       (level),
        .last_write  (last_write)
    );

endmodule
